// ===== design/wcx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the window coverage extremes block.
// No dependencies; used by wcx_scan and window_coverage_extremes_core.
package wcx_pkg;

   // width of positions, lengths and start indexes on the ports
   localparam int FIELD_W = 13;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W = 2;

   // item kinds carried in req_tuser
   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TRACK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW = 2'd1;

   // configuration values after reset
   localparam logic [FIELD_W-1:0] TRACK_RESET = 13'd4096;
   localparam logic [FIELD_W-1:0] WINDOW_RESET = 13'd1;

   // control from the sequencer to the scan unit
   typedef struct packed {
      logic clear;   // new job: zero the running sum and answers
      logic take;    // read data belongs to a window start in range
      logic first;   // that start is start 1
   } scan_ctl_type;

endpackage

// ===== design/wcx_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port,
// registered read data, read-first on address collision. No dependencies.
module wcx_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 4098
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/wcx_scan.sv =====
`timescale 1ns / 1ps
// Prefix-sum scan unit: accumulates difference entries and keeps the
// first maximum and first minimum start. Depends on wcx_pkg.
module wcx_scan #(
   parameter int DW = 17
) (
   input  logic                        clock,
   input  logic                        reset,
   input  wcx_pkg::scan_ctl_type       ctl,
   input  logic [wcx_pkg::FIELD_W-1:0] pos,
   input  logic [DW-1:0]               data,
   output logic [wcx_pkg::FIELD_W-1:0] best_start,
   output logic [wcx_pkg::FIELD_W-1:0] worst_start
);
   import wcx_pkg::*;

   logic signed [DW-1:0] run_ff;
   logic signed [DW-1:0] max_ff;
   logic signed [DW-1:0] min_ff;
   logic [FIELD_W-1:0]   best_ff;
   logic [FIELD_W-1:0]   worst_ff;
   logic signed [DW-1:0] run_in;
   logic                 new_max;
   logic                 new_min;

   // next running sum and strict comparisons against the extremes
   always_comb begin
      run_in = run_ff + $signed(data);
      new_max = ctl.first || (run_in > max_ff);
      new_min = ctl.first || (run_in < min_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         best_ff <= '0;
         worst_ff <= '0;
      end else if (ctl.clear) begin
         run_ff <= '0;
         best_ff <= '0;
         worst_ff <= '0;
      end else if (ctl.take) begin
         run_ff <= run_in;
         if (new_max) begin
            best_ff <= pos;
         end
         if (new_min) begin
            worst_ff <= pos;
         end
      end
   end

   // extreme values: payload only, meaningful once a start was taken
   always_ff @(posedge clock) begin
      if (ctl.take && new_max) begin
         max_ff <= run_in;
      end
      if (ctl.take && new_min) begin
         min_ff <= run_in;
      end
   end

   assign best_start = best_ff;
   assign worst_start = worst_ff;

endmodule

// ===== design/window_coverage_extremes_core.sv =====
`timescale 1ns / 1ps
// Window coverage extremes core. Depends on wcx_pkg, wcx_ram, wcx_scan.
//
// Usage:
//   req_* carries items: tuser is the kind (add interval or finish job),
//   tdata holds left and right. An add item updates a difference memory
//   with two read-modify-write steps; a taken add passes through ST_ADD2
//   before the next item is taken, while an ignored add (bad interval, no
//   starts, limit reached) leaves the core in ST_IDLE. A finish item sweeps
//   the whole memory (MAX_POSITIONS+2 entries, one a cycle through the
//   single read port), summing the starts in range and zeroing every entry
//   behind it, then registers the answer in ST_DONE; req_tready stays low.
//   rsp_* carries one item per finish: best start, worst start, drop flag.
//   The answer sits in an output register; add items are taken while it
//   waits. A second finish holds its answer until rsp_tready frees it.
//   csr_* writes track_length (index 0) and window_length (index 1); it is
//   always ready and is meant to be used while the core is idle.
//   After reset a clearing pass zeroes all MAX_POSITIONS+2 entries of the
//   memory; req_tready is low until it ends. Configuration is taken then.
module window_coverage_extremes_core #(
   parameter int MAX_POSITIONS = 4096,
   parameter int MAX_INTERVALS = 65535
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [wcx_pkg::REQ_DATA_W-1:0]       req_tdata,  // left[12:0], right[25:13]
   input  logic                                 req_tuser,  // action[0]
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [wcx_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // best_start[12:0],
                                                            // worst_start[25:13], dropped[26]
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wcx_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wcx_pkg::FIELD_W-1:0]          csr_data
);
   import wcx_pkg::*;

   localparam int DEPTH = MAX_POSITIONS + 2;
   localparam int AW = $clog2(DEPTH);
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam int DW = CNT_W + 1;
   localparam int PW = (AW > FIELD_W + 1) ? AW : FIELD_W + 1;
   localparam logic [31:0] MAXP = 32'(MAX_POSITIONS);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD2,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [FIELD_W-1:0] track_ff;
   logic [FIELD_W-1:0] window_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               overflow_ff;
   logic               dropped_ff;
   logic [AW-1:0]      ptr_ff;
   logic [AW-1:0]      ptr_d_ff;
   logic               vld_d_ff;
   logic [AW-1:0]      lo_ff;
   logic [AW-1:0]      hi1_ff;
   logic               hi_pend_ff;
   logic               fwd_ff;
   logic [DW-1:0]      fwd_data_ff;
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_best_ff;
   logic [FIELD_W-1:0] rsp_worst_ff;
   logic               rsp_dropped_ff;

   logic [FIELD_W-1:0] eff_track;
   logic [FIELD_W-1:0] starts;
   logic [FIELD_W-1:0] req_left;
   logic [FIELD_W-1:0] req_right;
   logic [FIELD_W-1:0] lo_c;
   logic [FIELD_W-1:0] hi_c;
   logic [AW-1:0]      lo_addr_c;
   logic               iv_ok;
   logic               req_fire;
   logic               rsp_fire;
   logic               rsp_free;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [DW-1:0]      ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [DW-1:0]      ram_rdata;
   logic [DW-1:0]      add_base;
   scan_ctl_type       scan_ctl;
   logic [FIELD_W-1:0] scan_pos;
   logic [FIELD_W-1:0] scan_best;
   logic [FIELD_W-1:0] scan_worst;

   // effective track, number of window starts, interval clamping
   always_comb begin
      eff_track = ({19'd0, track_ff} > MAXP) ? FIELD_W'(MAXP) : track_ff;
      if (window_ff == '0 || window_ff > eff_track) begin
         starts = '0;
      end else begin
         starts = eff_track - window_ff + FIELD_W'(1);
      end
      req_left = req_tdata[FIELD_W-1:0];
      req_right = req_tdata[2*FIELD_W-1:FIELD_W];
      iv_ok = (starts != '0) && (req_left != '0) && (req_left <= req_right)
              && (req_right <= eff_track);
      lo_c = (req_left >= window_ff) ? req_left - window_ff + FIELD_W'(1)
                                     : FIELD_W'(1);
      hi_c = (req_right < starts) ? req_right : starts;
      lo_addr_c = AW'(lo_c);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_valid_ff && rsp_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;
   assign add_base = fwd_ff ? fwd_data_ff : ram_rdata;

   // memory port steering
   always_comb begin
      ram_we = 1'b0;
      ram_waddr = ptr_ff;
      ram_wdata = '0;
      ram_raddr = ptr_ff;
      case (state_ff)
         ST_IDLE: begin
            ram_we = hi_pend_ff;
            ram_waddr = hi1_ff;
            ram_wdata = ram_rdata - DW'(1);
            ram_raddr = lo_addr_c;
         end
         ST_ADD2: begin
            ram_we = 1'b1;
            ram_waddr = lo_ff;
            ram_wdata = add_base + DW'(1);
            ram_raddr = hi1_ff;
         end
         ST_CLEAR, ST_SCAN: begin
            ram_we = 1'b1;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // scan control from the delayed sweep pointer
   always_comb begin
      scan_ctl.clear = req_fire && (req_tuser == ACT_FINISH);
      scan_ctl.take = vld_d_ff && (PW'(ptr_d_ff) >= PW'(1))
                      && (PW'(ptr_d_ff) <= PW'(starts));
      scan_ctl.first = (PW'(ptr_d_ff) == PW'(1));
      scan_pos = FIELD_W'(ptr_d_ff);
   end

   // sequencer, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         track_ff <= TRACK_RESET;
         window_ff <= WINDOW_RESET;
         count_ff <= '0;
         overflow_ff <= 1'b0;
         ptr_ff <= '0;
         vld_d_ff <= 1'b0;
         hi_pend_ff <= 1'b0;
         fwd_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // configuration writes
         if (csr_valid) begin
            case (csr_index)
               REG_TRACK:  track_ff <= csr_data;
               REG_WINDOW: window_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         hi_pend_ff <= 1'b0;
         vld_d_ff <= 1'b0;
         ptr_d_ff <= ptr_ff;
         case (state_ff)
            ST_CLEAR: begin
               ptr_ff <= ptr_ff + AW'(1);
               if (ptr_ff == LAST_ADDR) begin
                  ptr_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire && req_tuser == ACT_FINISH) begin
                  dropped_ff <= overflow_ff;
                  count_ff <= '0;
                  overflow_ff <= 1'b0;
                  ptr_ff <= '0;
                  state_ff <= ST_SCAN;
               end else if (req_fire && iv_ok) begin
                  if (count_ff == CNT_MAX) begin
                     overflow_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                     lo_ff <= lo_addr_c;
                     hi1_ff <= AW'({1'b0, hi_c} + 14'd1);
                     fwd_ff <= hi_pend_ff && (hi1_ff == lo_addr_c);
                     fwd_data_ff <= ram_rdata - DW'(1);
                     state_ff <= ST_ADD2;
                  end
               end
            end
            ST_ADD2: begin
               hi_pend_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_SCAN: begin
               vld_d_ff <= 1'b1;
               ptr_ff <= ptr_ff + AW'(1);
               if (ptr_ff == LAST_ADDR) begin
                  ptr_ff <= '0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_best_ff <= scan_best;
                  rsp_worst_ff <= scan_worst;
                  rsp_dropped_ff <= dropped_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   wcx_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_diff_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   wcx_scan #(
      .DW (DW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .pos         (scan_pos),
      .data        (ram_rdata),
      .best_start  (scan_best),
      .worst_start (scan_worst)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - 2*FIELD_W - 1){1'b0}}, rsp_dropped_ff,
                       rsp_worst_ff, rsp_best_ff};

`ifndef SYNTHESIS
   // the second update of an add never collides with the first
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD2 |-> ram_waddr != ram_raddr)
      else $error("add update read and write hit the same entry");

   // a result only appears at the end of a scan
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside scan completion");

   // the per-job interval count stays within its limit
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("interval count beyond limit");

   // a finish item starts the sweep and restarts the job counters
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == ACT_FINISH |=> state_ff == ST_SCAN
                                              && count_ff == '0 && !overflow_ff)
      else $error("finish did not start a clean scan");
`endif

endmodule
